// ===== design/ihex_pkg.sv =====
// Shared types, constants and helpers for the Intel HEX record encoder.
package ihex_pkg;

    // Input item: a data byte or a finish command
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_item_t;

    // Result item: one ASCII character of the hex text
    typedef struct packed {
        logic [6:0] text_char;
        logic       last_char;
    } out_item_t;

    // Work handed from the front to the back
    typedef struct packed {
        logic        eof;       // end-of-file record only
        logic        need_ext;  // extended linear address record goes first
        logic [31:0] addr;      // record address
        logic        slot;      // record buffer half that holds the bytes
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_COLON,
        BK_HI,
        BK_LO,
        BK_CR,
        BK_LF
    } back_state_t;

    typedef enum logic [1:0] {
        REC_EXT,
        REC_DATA,
        REC_EOF
    } rec_kind_t;

    // Command codes
    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Characters
    localparam logic [6:0] CHAR_COLON = 7'h3A;
    localparam logic [6:0] CHAR_CR    = 7'h0D;
    localparam logic [6:0] CHAR_LF    = 7'h0A;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h41;

    // Record fields
    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;
    localparam logic [7:0] TYPE_EXT  = 8'h04;
    localparam logic [7:0] EXT_LEN   = 8'h02;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    // Header bytes before the payload: length, address high, address low, type
    localparam int HDR_BYTES = 4;

    // Record buffer halves and job queue depth
    localparam logic [1:0] BUF_SLOTS  = 2'd2;
    localparam logic [1:0] JOBQ_DEPTH = 2'd2;

    // Configuration register map
    localparam int         PADDR_W       = 3;
    localparam logic       REG_BASE_ADDR = 1'b0;  // register index, paddr[2]

    // Uppercase hex digit for one nibble
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] wide;
        wide = {3'b000, nib};
        if (nib < 4'd10) begin
            return CHAR_ZERO + wide;
        end else begin
            return CHAR_A + wide - 7'd10;
        end
    endfunction

endpackage

// ===== design/intel_hex_record_encoder.sv =====
// Intel HEX record encoder top level: APB register, front, job queue, back end.
//
// Input channel s_*: one transfer per binary byte (command 0) or finish
// command (command 1). Output channel m_*: one ASCII character per transfer;
// last_char marks the final character caused by an input item.
// APB register 0 (byte address 0) holds base_address; write it only while idle.
//
// A byte that does not complete a record is accepted and gives no
// output. The byte that completes a record queues a job; the back end then
// emits an optional 17-character extended address record and the
// 13 + 2*RECORD_BYTES character data record at one character per cycle
// while m_ready is high. A finish gives 13 characters. The first character
// follows the completing transfer through the job queue, the sequencer
// state and the output register.
// The record buffer has two halves, so the front keeps taking bytes while
// the previous record is sent; it stalls once both halves are held. Output
// rate is bound by the back end's one character per cycle.
// When m_ready is low the output register holds and the back end waits;
// the front keeps accepting until the queue or buffer fills.
// Reset (aresetn low, synchronous) clears the stream state, queue, output
// valid and base_address; the next record starts with an extended record.
module intel_hex_record_encoder #(
    parameter int RECORD_BYTES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  ihex_pkg::in_item_t             s_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    // output channel
    output ihex_pkg::out_item_t            m_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ihex_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ihex_pkg::*;

    localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    logic [31:0]      base_address_reg;
    logic             cfg_write;
    logic             reg_sel;

    job_t             front_job;
    logic             job_push;
    logic             q_ready;
    job_t             q_job;
    logic             q_valid;
    logic             q_pop;
    logic             slot_release;
    logic             rd_slot;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       rd_data;

    // Configuration register
    assign pready    = 1'b1;
    assign reg_sel   = paddr[PADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_sel == REG_BASE_ADDR) ? base_address_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_address_reg <= '0;
        end else if (cfg_write && (reg_sel == REG_BASE_ADDR)) begin
            base_address_reg <= pwdata;
        end
    end

    ihex_front #(
        .RECORD_BYTES (RECORD_BYTES),
        .IDX_W        (IDX_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_data       (s_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .base_address (base_address_reg),
        .job          (front_job),
        .job_push     (job_push),
        .job_ready    (q_ready),
        .slot_release (slot_release),
        .rd_slot      (rd_slot),
        .rd_idx       (rd_idx),
        .rd_data      (rd_data)
    );

    ihex_jobq u_jobq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_job    (front_job),
        .in_push   (job_push),
        .in_ready  (q_ready),
        .out_job   (q_job),
        .out_valid (q_valid),
        .out_pop   (q_pop)
    );

    ihex_back #(
        .RECORD_BYTES (RECORD_BYTES),
        .IDX_W        (IDX_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job          (q_job),
        .job_valid    (q_valid),
        .job_pop      (q_pop),
        .rd_slot      (rd_slot),
        .rd_idx       (rd_idx),
        .rd_data      (rd_data),
        .slot_release (slot_release),
        .m_data       (m_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

    // Every record, and so every item's output, ends with LF
    a_last_is_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last_char) |-> (m_data.text_char == CHAR_LF))
        else $error("last character is not LF");

    // The front never pushes a job into a full queue
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> q_ready)
        else $error("job pushed into full queue");

    // The back only takes a job that is there
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("job popped from empty queue");

    // Output channel is empty after reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

// ===== design/ihex_front.sv =====
// Front end: accepts bytes and commands, fills the record buffer, issues jobs.
module ihex_front #(
    parameter int RECORD_BYTES = 16,
    parameter int IDX_W        = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ihex_pkg::in_item_t s_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        base_address,
    output ihex_pkg::job_t     job,
    output logic               job_push,
    input  logic               job_ready,
    input  logic               slot_release,
    input  logic               rd_slot,
    input  logic [IDX_W-1:0]   rd_idx,
    output logic [7:0]         rd_data
);
    import ihex_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_BYTES - 1);
    localparam logic [31:0]      REC_STEP = 32'(RECORD_BYTES);
    localparam int               MEM_DEPTH = 2 ** (IDX_W + 1);

    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             wslot_reg, wslot_next;
    logic [31:0]      offset_reg, offset_next;
    logic [15:0]      upper_reg, upper_next;
    logic             upper_valid_reg, upper_valid_next;
    logic [1:0]       slots_used_reg, slots_used_next;

    logic [7:0]       mem [MEM_DEPTH];
    logic [7:0]       rd_data_reg;

    logic             accept;
    logic             is_finish;
    logic             rec_done;
    logic [31:0]      rec_addr;

    // Handshake and classification
    assign s_ready   = job_ready && (slots_used_reg != BUF_SLOTS);
    assign accept    = s_valid && s_ready;
    assign is_finish = (s_data.command == CMD_FINISH);
    assign rec_done  = accept && !is_finish && (cnt_reg == LAST_IDX);
    assign rec_addr  = base_address + offset_reg;
    assign job_push  = accept && (is_finish || rec_done);

    assign job.eof      = is_finish;
    assign job.need_ext = !upper_valid_reg || (rec_addr[31:16] != upper_reg);
    assign job.addr     = rec_addr;
    assign job.slot     = wslot_reg;

    // Stream state
    always_comb begin
        cnt_next         = cnt_reg;
        wslot_next       = wslot_reg;
        offset_next      = offset_reg;
        upper_next       = upper_reg;
        upper_valid_next = upper_valid_reg;
        if (accept) begin
            if (is_finish) begin
                cnt_next         = '0;
                offset_next      = '0;
                upper_valid_next = 1'b0;
            end else if (rec_done) begin
                cnt_next         = '0;
                offset_next      = offset_reg + REC_STEP;
                upper_next       = rec_addr[31:16];
                upper_valid_next = 1'b1;
                wslot_next       = !wslot_reg;
            end else begin
                cnt_next = cnt_reg + IDX_W'(1);
            end
        end
    end

    // Buffer halves in use by queued or running record jobs
    always_comb begin
        slots_used_next = slots_used_reg;
        if (rec_done && !slot_release) begin
            slots_used_next = slots_used_reg + 2'd1;
        end else if (!rec_done && slot_release) begin
            slots_used_next = slots_used_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg         <= '0;
            wslot_reg       <= 1'b0;
            offset_reg      <= '0;
            upper_reg       <= '0;
            upper_valid_reg <= 1'b0;
            slots_used_reg  <= '0;
        end else begin
            cnt_reg         <= cnt_next;
            wslot_reg       <= wslot_next;
            offset_reg      <= offset_next;
            upper_reg       <= upper_next;
            upper_valid_reg <= upper_valid_next;
            slots_used_reg  <= slots_used_next;
        end
    end

    // Record buffer, two halves; back end reads the other half
    always_ff @(posedge aclk) begin
        if (accept && !is_finish) begin
            mem[{wslot_reg, cnt_reg}] <= s_data.data_byte;
        end
        rd_data_reg <= mem[{rd_slot, rd_idx}];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ihex_jobq.sv =====
// Two-entry job queue between the front and the back end.
module ihex_jobq (
    input  logic           aclk,
    input  logic           aresetn,
    input  ihex_pkg::job_t in_job,
    input  logic           in_push,
    output logic           in_ready,
    output ihex_pkg::job_t out_job,
    output logic           out_valid,
    input  logic           out_pop
);
    import ihex_pkg::*;

    job_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign in_ready  = (count_reg != JOBQ_DEPTH);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = q_reg[rd_ptr_reg];

    // Pointer and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (out_pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (in_push && !out_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!in_push && out_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (in_push) begin
            q_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ===== design/ihex_back.sv =====
// Back end: walks each job's records and emits their characters, one per cycle while the output is not stalled.
module ihex_back #(
    parameter int RECORD_BYTES = 16,
    parameter int IDX_W        = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ihex_pkg::job_t      job,
    input  logic                job_valid,
    output logic                job_pop,
    output logic                rd_slot,
    output logic [IDX_W-1:0]    rd_idx,
    input  logic [7:0]          rd_data,
    output logic                slot_release,
    output ihex_pkg::out_item_t m_data,
    output logic                m_valid,
    input  logic                m_ready
);
    import ihex_pkg::*;

    localparam int BI_W = $clog2(RECORD_BYTES + 7);
    localparam logic [BI_W-1:0] NB_EXT  = BI_W'(6);
    localparam logic [BI_W-1:0] NB_DATA = BI_W'(HDR_BYTES + RECORD_BYTES);
    localparam logic [BI_W-1:0] NB_EOF  = BI_W'(HDR_BYTES);
    localparam logic [BI_W-1:0] BI_HDR  = BI_W'(HDR_BYTES);
    localparam logic [7:0]      LEN_DATA = 8'(RECORD_BYTES);

    back_state_t      state_reg, state_next;
    rec_kind_t        kind_reg, kind_next;
    logic [BI_W-1:0]  idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic [31:0]      addr_reg, addr_next;
    logic             slot_reg, slot_next;

    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic             adv;
    logic [BI_W-1:0]  nbytes;
    logic [BI_W-1:0]  rd_off;
    logic [7:0]       cur_byte;
    logic [7:0]       chksum;
    logic             emit_valid;
    logic [6:0]       emit_char;
    logic             emit_last;

    // The sequencer moves whenever the output register can take a character
    assign adv = !m_valid_reg || m_ready;

    // Byte count of the current record, checksum excluded
    always_comb begin
        unique case (kind_reg)
            REC_EXT:  nbytes = NB_EXT;
            REC_DATA: nbytes = NB_DATA;
            REC_EOF:  nbytes = NB_EOF;
            default:  nbytes = NB_EOF;
        endcase
    end

    // Byte at the current position of the record
    assign chksum = 8'd0 - sum_reg;

    always_comb begin
        cur_byte = BYTE_ZERO;
        if (idx_reg == nbytes) begin
            cur_byte = chksum;
        end else begin
            unique case (kind_reg)
                REC_EXT: begin
                    priority if (idx_reg == BI_W'(0)) cur_byte = EXT_LEN;
                    else if (idx_reg == BI_W'(3))     cur_byte = TYPE_EXT;
                    else if (idx_reg == BI_W'(4))     cur_byte = addr_reg[31:24];
                    else if (idx_reg == BI_W'(5))     cur_byte = addr_reg[23:16];
                    else                              cur_byte = BYTE_ZERO;
                end
                REC_DATA: begin
                    priority if (idx_reg == BI_W'(0)) cur_byte = LEN_DATA;
                    else if (idx_reg == BI_W'(1))     cur_byte = addr_reg[15:8];
                    else if (idx_reg == BI_W'(2))     cur_byte = addr_reg[7:0];
                    else if (idx_reg == BI_W'(3))     cur_byte = TYPE_DATA;
                    else                              cur_byte = rd_data;
                end
                REC_EOF: begin
                    if (idx_reg == BI_W'(3)) cur_byte = TYPE_EOF;
                    else                     cur_byte = BYTE_ZERO;
                end
                default: cur_byte = BYTE_ZERO;
            endcase
        end
    end

    // Next state and sequencer datapath
    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        addr_next    = addr_reg;
        slot_next    = slot_reg;
        job_pop      = 1'b0;
        slot_release = 1'b0;
        if (adv) begin
            unique case (state_reg)
                BK_IDLE: begin
                    if (job_valid) begin
                        job_pop   = 1'b1;
                        addr_next = job.addr;
                        slot_next = job.slot;
                        idx_next  = '0;
                        sum_next  = '0;
                        if (job.eof) begin
                            kind_next = REC_EOF;
                        end else if (job.need_ext) begin
                            kind_next = REC_EXT;
                        end else begin
                            kind_next = REC_DATA;
                        end
                        state_next = BK_COLON;
                    end
                end
                BK_COLON: state_next = BK_HI;
                BK_HI:    state_next = BK_LO;
                BK_LO: begin
                    sum_next = sum_reg + cur_byte;
                    if (idx_reg == nbytes) begin
                        state_next = BK_CR;
                    end else begin
                        idx_next   = idx_reg + BI_W'(1);
                        state_next = BK_HI;
                    end
                end
                BK_CR:    state_next = BK_LF;
                BK_LF: begin
                    if (kind_reg == REC_EXT) begin
                        kind_next  = REC_DATA;
                        idx_next   = '0;
                        sum_next   = '0;
                        state_next = BK_COLON;
                    end else begin
                        slot_release = (kind_reg == REC_DATA);
                        state_next   = BK_IDLE;
                    end
                end
                default: state_next = BK_IDLE;
            endcase
        end
    end

    // Buffer read address comes from idx_next, so the registered data is ready at the byte's high digit
    assign rd_off  = idx_next - BI_HDR;
    assign rd_idx  = rd_off[IDX_W-1:0];
    assign rd_slot = slot_next;

    // Character for the current state
    always_comb begin
        emit_valid = 1'b1;
        emit_char  = CHAR_COLON;
        emit_last  = 1'b0;
        unique case (state_reg)
            BK_IDLE:  emit_valid = 1'b0;
            BK_COLON: emit_char  = CHAR_COLON;
            BK_HI:    emit_char  = hex_char(cur_byte[7:4]);
            BK_LO:    emit_char  = hex_char(cur_byte[3:0]);
            BK_CR:    emit_char  = CHAR_CR;
            BK_LF: begin
                emit_char = CHAR_LF;
                emit_last = (kind_reg != REC_EXT);
            end
            default:  emit_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            kind_reg    <= REC_EOF;
            idx_reg     <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            if (adv) begin
                m_valid_reg <= emit_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        slot_reg <= slot_next;
        if (adv) begin
            m_data_reg.text_char <= emit_char;
            m_data_reg.last_char <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== bench/intel_hex_record_encoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Intel HEX record encoder.
module intel_hex_record_encoder_tb;
    import ihex_pkg::*;

    localparam int REC_LEN       = 16;
    localparam int IDLE_PCT      = 17;
    localparam int HOLD_CYCLES   = 500;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 36;
    localparam int FINISH_PCT    = 3;
    localparam int FILL_AT_ITEM  = 150;
    localparam logic [PADDR_W-1:0] BASE_ADDR_REG = {REG_BASE_ADDR, 2'b00};

    logic                aclk;
    logic                aresetn;
    in_item_t            s_data;
    logic                s_valid;
    logic                s_ready;
    out_item_t           m_data;
    logic                m_valid;
    logic                m_ready;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Encoder state as the bench sees it
    logic [7:0]  rec_bytes [REC_LEN];
    logic [4:0]  fill_count;
    logic [31:0] rec_offset;
    logic [15:0] last_upper;
    logic        upper_sent;
    logic [31:0] base_reg;
    logic [7:0]  rec_sum;
    logic [6:0]  chars_out [$];

    // Characters still owed by the block, oldest first
    out_item_t   text_due [$];

    typedef struct {
        in_item_t item;
        string    text;
    } stim_row_t;
    stim_row_t   stim_rows [$];

    int          sent_count;
    int          chars_seen;
    int          errors;
    int          stuck_cycles;
    bit          fill_req;

    intel_hex_record_encoder #(
        .RECORD_BYTES(REC_LEN)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic logic [6:0] digit_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CHAR_ZERO + {3'b000, nib};
        end else begin
            return CHAR_A + {3'b000, nib} - 7'd10;
        end
    endfunction

    function automatic void put_hex(input logic [7:0] b);
        chars_out.push_back(digit_char(b[7:4]));
        chars_out.push_back(digit_char(b[3:0]));
        rec_sum = rec_sum + b;
    endfunction

    function automatic void open_record();
        rec_sum = 8'h00;
        chars_out.push_back(CHAR_COLON);
    endfunction

    // Two's-complement checksum, then CR LF
    function automatic void close_record();
        put_hex(~rec_sum + 8'd1);
        chars_out.push_back(CHAR_CR);
        chars_out.push_back(CHAR_LF);
    endfunction

    // Advance the bench state by one accepted item; text lands in chars_out
    function automatic void encode_item(input in_item_t item);
        logic [31:0] addr;
        logic [15:0] upper;
        chars_out.delete();
        if (item.command == CMD_FINISH) begin
            open_record();
            put_hex(BYTE_ZERO);
            put_hex(BYTE_ZERO);
            put_hex(BYTE_ZERO);
            put_hex(TYPE_EOF);
            close_record();
            fill_count = '0;
            rec_offset = '0;
            upper_sent = 1'b0;
        end else begin
            rec_bytes[fill_count[3:0]] = item.data_byte;
            fill_count = fill_count + 5'd1;
            if (fill_count >= REC_LEN) begin
                addr  = base_reg + rec_offset;
                upper = addr[31:16];
                // extended linear address record when the upper half is new
                if (!upper_sent || upper != last_upper) begin
                    open_record();
                    put_hex(EXT_LEN);
                    put_hex(BYTE_ZERO);
                    put_hex(BYTE_ZERO);
                    put_hex(TYPE_EXT);
                    put_hex(upper[15:8]);
                    put_hex(upper[7:0]);
                    close_record();
                    last_upper = upper;
                    upper_sent = 1'b1;
                end
                open_record();
                put_hex(8'(REC_LEN));
                put_hex(addr[15:8]);
                put_hex(addr[7:0]);
                put_hex(TYPE_DATA);
                for (int i = 0; i < REC_LEN; i++) put_hex(rec_bytes[i]);
                close_record();
                rec_offset = rec_offset + REC_LEN;
                fill_count = '0;
            end
        end
    endfunction

    // ---------------------------------------------------------------- drivers
    function automatic void add_row(input logic cmd, input logic [7:0] b, input string text);
        stim_row_t row;
        row.item.command   = cmd;
        row.item.data_byte = b;
        row.text           = text;
        stim_rows.push_back(row);
    endfunction

    // One input transfer; text, when given, replaces the predicted characters
    task automatic send_item(input in_item_t item, input string text);
        out_item_t due;
        byte       ch;
        int        n;
        while (!(sent_count >= 60 && sent_count < 120) && $urandom_range(99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = item;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        encode_item(item);
        if (text.len() != 0) begin
            chars_out.delete();
            for (int i = 0; i < text.len(); i++) begin
                ch = text[i];
                chars_out.push_back(ch[6:0]);
            end
        end
        n = chars_out.size();
        for (int i = 0; i < n; i++) begin
            due.text_char = chars_out[i];
            due.last_char = (i == n - 1);
            text_due.push_back(due);
        end
        sent_count++;
        if (sent_count == FILL_AT_ITEM) fill_req = 1'b1;
        @(negedge aclk);
    endtask

    // Wait for the block to go quiet before touching the register
    task automatic wait_drain();
        s_valid = 1'b0;
        while (text_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // APB write of base_address followed by a read back
    task automatic write_base(input logic [31:0] value);
        logic [31:0] readback;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = BASE_ADDR_REG;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        base_reg = value;
        penable  = 1'b0;
        pwrite   = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        readback = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== value) begin
            $error("base_address: expected %h, actual %h", value, readback);
            errors++;
        end
    endtask

    // ---------------------------------------------------------------- receiver
    initial begin : rx_ready
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            // long hold-off so the input side backs up
            if (fill_req) begin
                fill_req = 1'b0;
                m_ready  = 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++) @(negedge aclk);
            end
            if (chars_seen >= 300 && chars_seen < 600) begin
                m_ready = 1'b1;
            end else begin
                m_ready = ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare every output transfer with the oldest owed character
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            chars_seen++;
            if (text_due.size() == 0) begin
                $error("unexpected character %h", m_data.text_char);
                errors++;
            end else begin
                want = text_due.pop_front();
                if (want.text_char !== m_data.text_char) begin
                    $error("text_char: expected %h, actual %h",
                           want.text_char, m_data.text_char);
                    errors++;
                end
                if (want.last_char !== m_data.last_char) begin
                    $error("last_char: expected %b, actual %b",
                           want.last_char, m_data.last_char);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= WATCHDOG_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin : stimulus
        string       ff_rec;
        string       eof_rec;
        in_item_t    item;
        logic [31:0] bases [6];

        aresetn    = 1'b0;
        s_data     = '0;
        s_valid    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        fill_count = '0;
        rec_offset = '0;
        last_upper = '0;
        upper_sent = 1'b0;
        base_reg   = '0;
        rec_sum    = '0;
        sent_count = 0;
        chars_seen = 0;
        errors     = 0;
        stuck_cycles = 0;
        fill_req   = 1'b0;
        for (int i = 0; i < REC_LEN; i++) rec_bytes[i] = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        write_base(32'h0000_0000);

        // Directed: end-of-file right after reset, an all-ones record at
        // address zero (with its first extended record), then a partial
        // record that the finish throws away
        eof_rec = ":00000001FF\r\n";
        ff_rec  = ":020000040000FA\r\n:10000000";
        for (int i = 0; i < REC_LEN; i++) ff_rec = {ff_rec, "FF"};
        ff_rec = {ff_rec, "00\r\n"};
        add_row(CMD_FINISH, 8'h00, eof_rec);
        for (int i = 0; i < REC_LEN - 1; i++) add_row(CMD_DATA, 8'hFF, "");
        add_row(CMD_DATA, 8'hFF, ff_rec);
        add_row(CMD_DATA, 8'h00, "");
        add_row(CMD_DATA, 8'hA5, "");
        add_row(CMD_DATA, 8'h5A, "");
        add_row(CMD_FINISH, 8'hFF, eof_rec);
        foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].text);

        // Random phases, one base address each: upper half all ones, wrap
        // through zero, crossing a 64 KiB boundary, unaligned top, random, zero
        bases[0] = 32'hFFFF_0000;
        bases[1] = 32'hFFFF_FFF0;
        bases[2] = 32'h0000_FFF0;
        bases[3] = 32'hFFFF_FFFF;
        bases[4] = $urandom;
        bases[5] = 32'h0000_0000;
        foreach (bases[p]) begin
            wait_drain();
            write_base(bases[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                item.command   = ($urandom_range(99) < FINISH_PCT) ? CMD_FINISH : CMD_DATA;
                item.data_byte = 8'($urandom_range(255));
                send_item(item, "");
            end
            item.command   = CMD_FINISH;
            item.data_byte = 8'($urandom_range(255));
            send_item(item, "");
        end

        wait_drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
